### rtl/uarbd_pkg.sv
package uarbd_pkg;

    // Field widths
    localparam int RATE_W = 24;
    localparam int FAM_W  = 2;
    localparam int VAL_W  = 16;
    localparam int HIGH_W = 8;
    localparam int ENC_W  = VAL_W + HIGH_W;

    // Divider widths: numerator < 2^30, divisor < 2^28, quotient < 2^25
    localparam int NUM_W = 30;
    localparam int DIV_W = 28;
    localparam int QUO_W = 25;

    // Family register codes
    localparam logic [FAM_W-1:0] CFG_FAM_A = 2'd0;
    localparam logic [FAM_W-1:0] CFG_FAM_B = 2'd1;
    localparam logic [FAM_W-1:0] CFG_FAM_RESET = CFG_FAM_B;

    // Clock constants
    localparam logic [NUM_W-1:0]  LS_BASE     = 30'd24000000;
    localparam logic [NUM_W-1:0]  HS_BASE     = 30'd960000000;
    localparam logic [RATE_W-1:0] HS_MIN_RATE = 24'd1200;

    // Encoded divisor codes
    localparam logic [ENC_W-1:0] FRAC_CODE_1   = 24'h00c000;
    localparam logic [ENC_W-1:0] FRAC_CODE_HI  = 24'h004000;
    localparam logic [ENC_W-1:0] FRAC_CODE_MID = 24'h008000;
    localparam logic [ENC_W-1:0] ENC_ONE       = 24'h000001;
    localparam logic [ENC_W-1:0] ENC_SPECIAL   = 24'h004001;
    localparam logic [ENC_W-1:0] HS_FLAG       = 24'h020000;
    localparam int               FRAC_SHIFT    = 14;

    typedef enum logic [1:0] {
        FAM_A,
        FAM_B,
        FAM_H
    } family_t;

    typedef struct packed {
        logic    invalid;
        family_t fam;
    } ctrl_t;

    // One beat travelling through the divider
    typedef struct packed {
        ctrl_t              ctrl;
        logic [QUO_W-1:0]   num_lo;
        logic [DIV_W-1:0]   rem;
        logic [DIV_W-1:0]   dvsr;
        logic [QUO_W-1:0]   quot;
    } div_beat_t;

    // Fraction remap for type B and H
    function automatic logic [2:0] frac_map(input logic [2:0] f);
        logic [2:0] m;
        unique case (f)
            3'd0: m = 3'd0;
            3'd1: m = 3'd3;
            3'd2: m = 3'd2;
            3'd3: m = 3'd4;
            3'd4: m = 3'd1;
            3'd5: m = 3'd5;
            3'd6: m = 3'd6;
            3'd7: m = 3'd7;
            default: m = 3'd0;
        endcase
        return m;
    endfunction

endpackage

### rtl/uart_baud_divisor_encode.sv
// Baud divisor encoder: each beat on the input carries a requested baud rate and
// yields one beat on the output with the encoded fractional divisor for the family
// held in the configuration register (0 type A, 1 type B, 2 or 3 type H; reset 1).
// One rate is accepted every clock unless a held output has filled every stage.
// A register forms the numerator and divisor, a restoring divider resolves one
// quotient bit per stage over 25 stages, and a final register encodes the fraction.
// Output stalls back up stage by stage, so empty stages keep taking input. A family
// write applies to rates accepted after it; the config port is always ready.
module uart_baud_divisor_encode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [uarbd_pkg::FAM_W-1:0]  chip_family,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [uarbd_pkg::RATE_W-1:0] baud_rate,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [uarbd_pkg::VAL_W-1:0]  divisor_value,
    output logic [uarbd_pkg::HIGH_W-1:0] divisor_high,
    output logic                         rate_invalid
);

    logic [uarbd_pkg::FAM_W-1:0] family_reg;
    uarbd_pkg::div_beat_t        beat  [uarbd_pkg::QUO_W+1];
    logic                        valid [uarbd_pkg::QUO_W+1];
    logic                        ready [uarbd_pkg::QUO_W+1];

    assign cfg_ready = 1'b1;

    // Family register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            family_reg <= uarbd_pkg::CFG_FAM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            family_reg <= chip_family;
        end
    end

    // Operand stage
    uarbd_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .baud_rate (baud_rate),
        .family    (family_reg),
        .out_valid (valid[0]),
        .out_ready (ready[0]),
        .out_beat  (beat[0])
    );

    // Divider, one quotient bit per stage, MSB first
    for (genvar k = 0; k < uarbd_pkg::QUO_W; k++)
    begin : g_div
        uarbd_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[k]),
            .in_ready  (ready[k]),
            .in_beat   (beat[k]),
            .out_valid (valid[k+1]),
            .out_ready (ready[k+1]),
            .out_beat  (beat[k+1])
        );
    end

    // Fraction encode and output register
    uarbd_encode u_encode (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (valid[uarbd_pkg::QUO_W]),
        .in_ready      (ready[uarbd_pkg::QUO_W]),
        .in_beat       (beat[uarbd_pkg::QUO_W]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .divisor_value (divisor_value),
        .divisor_high  (divisor_high),
        .rate_invalid  (rate_invalid)
    );

    // Input only stalls when every stage is full behind a held output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a held output");

endmodule

### rtl/uarbd_prep.sv
module uarbd_prep (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [uarbd_pkg::RATE_W-1:0] baud_rate,
    input  logic [uarbd_pkg::FAM_W-1:0]  family,
    output logic                         out_valid,
    input  logic                         out_ready,
    output uarbd_pkg::div_beat_t         out_beat
);

    logic                         valid_reg;
    uarbd_pkg::div_beat_t         beat_reg;
    uarbd_pkg::div_beat_t         beat_next;
    uarbd_pkg::family_t           fam;
    logic [uarbd_pkg::RATE_W-1:0] rate_clamp;
    logic [uarbd_pkg::NUM_W-1:0]  num;
    logic [uarbd_pkg::DIV_W-1:0]  dvsr;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    // Decode family; the spare code behaves as type H
    always_comb
    begin
        unique case (family)
            uarbd_pkg::CFG_FAM_A: fam = uarbd_pkg::FAM_A;
            uarbd_pkg::CFG_FAM_B: fam = uarbd_pkg::FAM_B;
            default:              fam = uarbd_pkg::FAM_H;
        endcase
    end

    // Numerator and divisor: type H uses rate*10 with rounding term rate*5
    always_comb
    begin
        rate_clamp = (baud_rate < uarbd_pkg::HS_MIN_RATE) ? uarbd_pkg::HS_MIN_RATE
                                                          : baud_rate;
        if (fam == uarbd_pkg::FAM_H)
        begin
            num  = uarbd_pkg::HS_BASE + (uarbd_pkg::NUM_W'(rate_clamp) << 2)
                   + uarbd_pkg::NUM_W'(rate_clamp);
            dvsr = (uarbd_pkg::DIV_W'(rate_clamp) << 3)
                   + (uarbd_pkg::DIV_W'(rate_clamp) << 1);
        end
        else
        begin
            num  = uarbd_pkg::LS_BASE + uarbd_pkg::NUM_W'(baud_rate >> 1);
            dvsr = uarbd_pkg::DIV_W'(baud_rate);
        end

        beat_next.ctrl.invalid = (baud_rate == '0);
        beat_next.ctrl.fam     = fam;
        beat_next.num_lo       = num[uarbd_pkg::QUO_W-1:0];
        beat_next.rem          = uarbd_pkg::DIV_W'(num[uarbd_pkg::NUM_W-1:uarbd_pkg::QUO_W]);
        beat_next.dvsr         = dvsr;
        beat_next.quot         = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

### rtl/uarbd_div_stage.sv
module uarbd_div_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  uarbd_pkg::div_beat_t in_beat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output uarbd_pkg::div_beat_t out_beat
);

    logic                          valid_reg;
    uarbd_pkg::div_beat_t          beat_reg;
    uarbd_pkg::div_beat_t          beat_next;
    logic [uarbd_pkg::DIV_W:0]     rem_sh;
    logic [uarbd_pkg::DIV_W:0]     diff;
    logic                          take;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    // One restoring step: bring down the next numerator bit, subtract if it fits
    always_comb
    begin
        rem_sh = {in_beat.rem, in_beat.num_lo[uarbd_pkg::QUO_W-1]};
        diff   = rem_sh - {1'b0, in_beat.dvsr};
        take   = (rem_sh >= {1'b0, in_beat.dvsr});

        beat_next        = in_beat;
        beat_next.num_lo = in_beat.num_lo << 1;
        beat_next.rem    = take ? diff[uarbd_pkg::DIV_W-1:0]
                                : rem_sh[uarbd_pkg::DIV_W-1:0];
        beat_next.quot   = {in_beat.quot[uarbd_pkg::QUO_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= beat_next;
        end
    end

    // Partial remainder always stays below the divisor
    a_rem_below_dvsr: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !beat_reg.ctrl.invalid |-> beat_reg.rem < beat_reg.dvsr)
        else $error("partial remainder not below divisor");

endmodule

### rtl/uarbd_encode.sv
module uarbd_encode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  uarbd_pkg::div_beat_t         in_beat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [uarbd_pkg::VAL_W-1:0]  divisor_value,
    output logic [uarbd_pkg::HIGH_W-1:0] divisor_high,
    output logic                         rate_invalid
);

    logic                          valid_reg;
    logic [uarbd_pkg::ENC_W-1:0]   enc_reg;
    logic [uarbd_pkg::ENC_W-1:0]   enc_next;
    logic                          invalid_reg;
    logic [uarbd_pkg::QUO_W-1:0]   q;
    logic [uarbd_pkg::QUO_W-1:0]   d3;
    logic [uarbd_pkg::ENC_W-1:0]   enc_a;
    logic [uarbd_pkg::ENC_W-1:0]   enc_bh;
    logic [uarbd_pkg::ENC_W-1:0]   enc_raw;

    assign in_ready      = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign divisor_value = enc_reg[uarbd_pkg::VAL_W-1:0];
    assign divisor_high  = enc_reg[uarbd_pkg::ENC_W-1:uarbd_pkg::VAL_W];
    assign rate_invalid  = invalid_reg;

    // Type A: round 7/8 up, then fraction code by rule
    always_comb
    begin
        q     = in_beat.quot;
        d3    = (q[2:0] == 3'd7) ? q + uarbd_pkg::QUO_W'(1) : q;
        enc_a = uarbd_pkg::ENC_W'(d3[uarbd_pkg::QUO_W-1:3]);
        priority if (d3[2:0] == 3'd1)
        begin
            enc_a = enc_a | uarbd_pkg::FRAC_CODE_1;
        end
        else if (d3[2] == 1'b1)
        begin
            enc_a = enc_a | uarbd_pkg::FRAC_CODE_HI;
        end
        else if (d3[2:0] != 3'd0)
        begin
            enc_a = enc_a | uarbd_pkg::FRAC_CODE_MID;
        end
        else
        begin
            // whole divisor of one encodes as zero
            enc_a = (enc_a == uarbd_pkg::ENC_ONE) ? '0 : enc_a;
        end
    end

    // Types B and H: remapped fraction, two special codes, H flag
    always_comb
    begin
        enc_raw = uarbd_pkg::ENC_W'(q[uarbd_pkg::QUO_W-1:3])
                  | (uarbd_pkg::ENC_W'(uarbd_pkg::frac_map(q[2:0]))
                     << uarbd_pkg::FRAC_SHIFT);
        priority if (enc_raw == uarbd_pkg::ENC_ONE)
        begin
            enc_bh = '0;
        end
        else if (enc_raw == uarbd_pkg::ENC_SPECIAL)
        begin
            enc_bh = uarbd_pkg::ENC_ONE;
        end
        else
        begin
            enc_bh = enc_raw;
        end
        if (in_beat.ctrl.fam == uarbd_pkg::FAM_H)
        begin
            enc_bh = enc_bh | uarbd_pkg::HS_FLAG;
        end
    end

    // Result select; zero rate gives zeros
    always_comb
    begin
        if (in_beat.ctrl.invalid)
        begin
            enc_next = '0;
        end
        else if (in_beat.ctrl.fam == uarbd_pkg::FAM_A)
        begin
            enc_next = enc_a;
        end
        else
        begin
            enc_next = enc_bh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            enc_reg     <= enc_next;
            invalid_reg <= in_beat.ctrl.invalid;
        end
    end

    // Zero rate reports an all-zero divisor
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && invalid_reg |-> enc_reg == '0)
        else $error("invalid rate with nonzero divisor");

    // Integer part is at most 22 bits, so the top two bits never set
    a_high_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> enc_reg[uarbd_pkg::ENC_W-1:uarbd_pkg::ENC_W-2] == 2'b00)
        else $error("divisor high byte out of range");

endmodule

### sim/tb_uart_baud_divisor_encode.sv
module tb_uart_baud_divisor_encode;

    timeunit 1ns;
    timeprecision 1ps;

    // Type H codes; the package names only A and B
    localparam logic [1:0] FAM_H_CODE  = 2'd2;
    localparam logic [1:0] FAM_H_ALIAS = 2'd3;

    localparam int          STALL_LIMIT = 5000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          FLOOD_HOLD = 300;
    localparam int unsigned HS_FLAG_BIT = 32'h0002_0000;

    localparam logic [2:0] FRAC_REMAP [8] = '{3'd0, 3'd3, 3'd2, 3'd4, 3'd1, 3'd5, 3'd6, 3'd7};

    localparam int unsigned COMMON_BAUDS [12] = '{300, 1200, 2400, 9600, 19200, 38400,
        57600, 115200, 230400, 460800, 921600, 3000000};
    // Rates that land on rounding and remap corner cases
    localparam int unsigned EDGE_RATES [6] = '{1200, 2000000, 3000000, 8000000,
        12000000, 1043478};

    typedef struct packed {
        logic [15:0] div_value;
        logic [7:0]  div_high;
        logic        bad_rate;
    } divisor_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  chip_family = uarbd_pkg::CFG_FAM_B;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [23:0] baud_rate = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] divisor_value;
    logic [7:0]  divisor_high;
    logic        rate_invalid;

    logic [23:0] pending_rates[$];
    divisor_t    expected_divisors[$];
    logic [1:0]  active_family = uarbd_pkg::CFG_FAM_B;
    int          rates_outstanding = 0;
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_req = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    bit          rate_beat_taken = 1'b0;

    uart_baud_divisor_encode dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .chip_family   (chip_family),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .baud_rate     (baud_rate),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .divisor_value (divisor_value),
        .divisor_high  (divisor_high),
        .rate_invalid  (rate_invalid)
    );

    always #4 clk = ~clk;

    // Encoded divisor for one rate, 32-bit unsigned arithmetic
    function automatic divisor_t encode_divisor(input logic [23:0] rate, input logic [1:0] fam);
        divisor_t    res;
        logic [31:0] r32;
        logic [31:0] d;
        logic [31:0] enc;
        logic [2:0]  frac;
        res = '0;
        if (rate == '0)
        begin
            res.bad_rate = 1'b1;
            return res;
        end
        r32 = 32'(rate);
        if (fam == uarbd_pkg::CFG_FAM_A)
        begin
            d = (32'(uarbd_pkg::LS_BASE) + r32 / 2) / r32;
            // fraction of 7/8 rounds up to the next integer
            if (d[2:0] == 3'd7)
                d = d + 1;
            enc = d >> 3;
            frac = d[2:0];
            if (frac == 3'd1)
                enc = enc | 32'(uarbd_pkg::FRAC_CODE_1);
            else if (frac >= 3'd4)
                enc = enc | 32'(uarbd_pkg::FRAC_CODE_HI);
            else if (frac != 3'd0)
                enc = enc | 32'(uarbd_pkg::FRAC_CODE_MID);
            else if (enc == 32'd1)
                enc = '0;
        end
        else
        begin
            if (fam == uarbd_pkg::CFG_FAM_B)
                d = (32'(uarbd_pkg::LS_BASE) + r32 / 2) / r32;
            else
            begin
                if (r32 < 32'(uarbd_pkg::HS_MIN_RATE))
                    r32 = 32'(uarbd_pkg::HS_MIN_RATE);
                d = (32'(uarbd_pkg::HS_BASE) + r32 * 5) / (r32 * 10);
            end
            enc = (d >> 3) | (32'(FRAC_REMAP[d[2:0]]) << 14);
            if (enc == 32'(uarbd_pkg::ENC_ONE))
                enc = '0;
            else if (enc == 32'(uarbd_pkg::ENC_SPECIAL))
                enc = 32'd1;
            if (fam != uarbd_pkg::CFG_FAM_B)
                enc = enc | HS_FLAG_BIT;
        end
        res.div_value = enc[15:0];
        res.div_high = enc[23:16];
        return res;
    endfunction

    // Random rate mix: full range, standard bauds, slow, fast, zero, corner cases
    function automatic logic [23:0] pick_rate();
        int          sel;
        int unsigned base;
        logic [23:0] r;
        sel = $urandom_range(99);
        if (sel < 30)
            r = 24'($urandom());
        else if (sel < 55)
        begin
            base = COMMON_BAUDS[$urandom_range(11)];
            r = 24'(base - 4 + $urandom_range(8));
        end
        else if (sel < 70)
            r = 24'($urandom_range(2000, 1));
        else if (sel < 85)
            r = 24'($urandom_range(24'hFFFFFF, 500000));
        else if (sel < 88)
            r = '0;
        else
        begin
            base = EDGE_RATES[$urandom_range(5)];
            r = 24'(base - 2 + $urandom_range(4));
        end
        return r;
    endfunction

    task automatic queue_rate(input logic [23:0] rate);
        pending_rates.push_back(rate);
        rates_outstanding++;
    endtask

    // Sender pauses here until every queued rate has its result
    task automatic wait_drained();
        while (rates_outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_family(input logic [1:0] code);
        @(negedge clk);
        cfg_valid <= 1'b1;
        chip_family <= code;
        do
            @(posedge clk);
        while (!cfg_ready);
        active_family = code;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [1:0] fam, input int send_pct,
                                    input int recv_pct, input int n_items, input int hold);
        write_family(fam);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        hold_req = hold;
        repeat (n_items)
            queue_rate(pick_rate());
        wait_drained();
    endtask

    // Rate beat driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || rate_beat_taken)
            begin
                rate_beat_taken = 1'b0;
                if (pending_rates.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    baud_rate <= pending_rates.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Predict on accepted rates, check accepted results
    always @(posedge clk)
    begin
        divisor_t got;
        divisor_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_divisors.push_back(encode_divisor(baud_rate, active_family));
                rate_beat_taken = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                got.div_value = divisor_value;
                got.div_high = divisor_high;
                got.bad_rate = rate_invalid;
                if (expected_divisors.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: value=%h high=%h invalid=%b",
                                 got.div_value, got.div_high, got.bad_rate);
                end
                else
                begin
                    want = expected_divisors.pop_front();
                    rates_outstanding--;
                    if (got.div_value !== want.div_value || got.div_high !== want.div_high ||
                        got.bad_rate !== want.bad_rate)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("divisor error: exp value=%h high=%h invalid=%b, got value=%h high=%h invalid=%b",
                                     want.div_value, want.div_high, want.bad_rate,
                                     got.div_value, got.div_high, got.bad_rate);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("uart_baud_divisor_encode: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset family B, zero rate, extremes, e=1 and e=0x4001 remaps
        queue_rate(24'd0);
        queue_rate(24'd1);
        queue_rate(24'hFFFFFF);
        queue_rate(24'd3000000);
        queue_rate(24'd2000000);
        queue_rate(24'd115200);
        wait_drained();

        // Type A: wide integer part, 7/8 round-up, 1/8 code, divisor 1 to zero
        write_family(uarbd_pkg::CFG_FAM_A);
        queue_rate(24'd1);
        queue_rate(24'h800000);
        queue_rate(24'h7FFFFF);
        queue_rate(24'd3000000);
        queue_rate(24'd1043478);
        queue_rate(24'd1411765);
        wait_drained();

        // Type H: clamp below 1200, remap corners, top rate
        write_family(FAM_H_CODE);
        queue_rate(24'd1);
        queue_rate(24'd1199);
        queue_rate(24'd1200);
        queue_rate(24'd12000000);
        queue_rate(24'd8000000);
        queue_rate(24'hFFFFFF);
        wait_drained();

        // Unused family code behaves as type H
        write_family(FAM_H_ALIAS);
        queue_rate(24'd0);
        queue_rate(24'd3000000);
        queue_rate(24'd921600);
        queue_rate(24'h555555);
        queue_rate(24'hAAAAAA);
        queue_rate(24'd12000000);
        wait_drained();

        run_random_phase(uarbd_pkg::CFG_FAM_B, 0, 0, 150, 0);
        run_random_phase(uarbd_pkg::CFG_FAM_A, 82, 0, 120, 0);
        run_random_phase(FAM_H_CODE, 0, 82, 120, 0);
        run_random_phase(FAM_H_ALIAS, 27, 27, 120, 0);
        // Receiver holds off while the sender floods, so the input stalls
        run_random_phase(uarbd_pkg::CFG_FAM_A, 0, 0, 150, FLOOD_HOLD);
        run_random_phase(FAM_H_CODE, 27, 27, 130, 0);
        run_random_phase(uarbd_pkg::CFG_FAM_B, 0, 82, 130, 0);
        run_random_phase(uarbd_pkg::CFG_FAM_A, 82, 0, 130, 0);

        // Let any stray beat show up before the verdict
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && expected_divisors.size() == 0)
            $display("uart_baud_divisor_encode: match");
        else
            $display("uart_baud_divisor_encode: mismatch");
        $finish;
    end

endmodule
